// ===== hw/rtl/fwcq_pkg.sv =====
// Package with the shared types and codes of the bounded queue with count queries.
`timescale 1ns / 1ps
`default_nettype none

package fwcq_pkg;

  localparam logic [2:0] ACT_PUSH    = 3'd0;
  localparam logic [2:0] ACT_POP     = 3'd1;
  localparam logic [2:0] ACT_GREATER = 3'd2;
  localparam logic [2:0] ACT_EVEN    = 3'd3;
  localparam logic [2:0] ACT_REVERSE = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam int CNT_W = 5;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] push_value;
    logic signed [31:0] threshold;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] popped_value;
    logic [CNT_W-1:0]   count_result;
    logic [1:0]         status;
    logic               is_empty;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_WB,
    S_COUNT,
    S_RV_RA,
    S_RV_RB,
    S_RV_WA,
    S_RV_WB,
    S_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic do_push;
    logic pop_rd;
    logic pop_wb;
    logic cnt_step;
    logic rv_rb;
    logic rv_wa;
    logic rv_wb;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] action;
    logic       empty;
    logic       cnt_done;
    logic       rv_done;
    logic       out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fwcq_ctrl.sv =====
// Controller state machine that sequences each request through the queue datapath.
`timescale 1ns / 1ps
`default_nettype none

module fwcq_ctrl
  import fwcq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire dp_sts_t sts,
  output dp_cmd_t      cmd
);

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.action)
          ACT_PUSH:    state_nxt = S_DONE;
          ACT_POP:     state_nxt = sts.empty ? S_DONE : S_POP_WB;
          ACT_GREATER: state_nxt = S_COUNT;
          ACT_EVEN:    state_nxt = S_COUNT;
          ACT_REVERSE: state_nxt = S_RV_RA;
          default:     state_nxt = S_DONE;
        endcase
      end
      S_POP_WB: state_nxt = S_DONE;
      S_COUNT: begin
        if (sts.cnt_done) begin
          state_nxt = S_DONE;
        end
      end
      S_RV_RA: state_nxt = sts.rv_done ? S_DONE : S_RV_RB;
      S_RV_RB: state_nxt = S_RV_WA;
      S_RV_WA: state_nxt = S_RV_WB;
      S_RV_WB: state_nxt = S_RV_RA;
      S_DONE: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      S_DISPATCH: begin
        cmd.do_push = (sts.action == ACT_PUSH);
        cmd.pop_rd  = (sts.action == ACT_POP);
      end
      S_POP_WB: cmd.pop_wb = 1'b1;
      S_COUNT:  cmd.cnt_step = !sts.cnt_done;
      S_RV_RB:  cmd.rv_rb = 1'b1;
      S_RV_WA:  cmd.rv_wa = 1'b1;
      S_RV_WB:  cmd.rv_wb = 1'b1;
      S_DONE:   cmd.out_load = sts.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fwcq_dp.sv =====
// Datapath with the entry memory, queue pointers, walk counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module fwcq_dp
  import fwcq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire in_item_t in_data,
  input  wire dp_cmd_t  cmd,
  output dp_sts_t       sts,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [31:0]        mem [DEPTH];
  logic [31:0]        rdata_r;
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic [31:0]        wdata;
  logic               we;

  logic [2:0]         act_r;
  logic [31:0]        val_r;
  logic signed [31:0] thr_r;
  logic [AW-1:0]      head_r;
  logic [CW-1:0]      occ_r;
  logic [CW-1:0]      idx_r;
  logic [CW-1:0]      jdx_r;
  logic               pend_r;
  logic [CNT_W-1:0]   count_r;
  logic [1:0]         status_r;
  logic [31:0]        popped_r;
  logic [31:0]        tmp_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic               full;
  logic               empty;
  logic               match;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] head,
                                         input logic [CW-1:0] pos);
    logic [CW:0] s;
    s = {{(CW + 1 - AW){1'b0}}, head} + {1'b0, pos};
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign full  = (occ_r == CW'(DEPTH));
  assign empty = (occ_r == '0);

  always_comb begin
    if (act_r == ACT_GREATER) begin
      match = ($signed(rdata_r) > thr_r);
    end else begin
      match = !rdata_r[0];
    end
  end

  always_comb begin
    raddr = slot(head_r, idx_r);
    if (cmd.pop_rd) begin
      raddr = head_r;
    end else if (cmd.rv_rb) begin
      raddr = slot(head_r, jdx_r);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = slot(head_r, idx_r);
    wdata = rdata_r;
    if (cmd.do_push) begin
      we    = !full;
      waddr = slot(head_r, occ_r);
      wdata = val_r;
    end else if (cmd.rv_wa) begin
      we = 1'b1;
    end else if (cmd.rv_wb) begin
      we    = 1'b1;
      waddr = slot(head_r, jdx_r);
      wdata = tmp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= in_data.action;
      val_r <= in_data.push_value;
      thr_r <= in_data.threshold;
      jdx_r <= empty ? '0 : occ_r - CW'(1);
      tmp_r <= '0;
    end else begin
      if (cmd.rv_rb) begin
        tmp_r <= rdata_r;
      end
      if (cmd.rv_wb) begin
        jdx_r <= jdx_r - CW'(1);
      end
    end
    if (cmd.out_load) begin
      out_r.popped_value <= popped_r;
      out_r.count_result <= count_r;
      out_r.status       <= status_r;
      out_r.is_empty     <= empty;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      occ_r       <= '0;
      idx_r       <= '0;
      pend_r      <= 1'b0;
      count_r     <= '0;
      status_r    <= ST_OK;
      popped_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r    <= '0;
        pend_r   <= 1'b0;
        count_r  <= '0;
        status_r <= ST_OK;
        popped_r <= '0;
      end
      if (cmd.do_push) begin
        if (full) begin
          status_r <= ST_FULL;
        end else begin
          occ_r <= occ_r + CW'(1);
        end
      end
      if (cmd.pop_rd && empty) begin
        status_r <= ST_EMPTY;
      end
      if (cmd.pop_wb) begin
        popped_r <= rdata_r;
        head_r   <= (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
        occ_r    <= occ_r - CW'(1);
      end
      if (cmd.cnt_step) begin
        if (pend_r && match) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (idx_r < occ_r) begin
          idx_r  <= idx_r + CW'(1);
          pend_r <= 1'b1;
        end else begin
          pend_r <= 1'b0;
        end
      end
      if (cmd.rv_wb) begin
        idx_r <= idx_r + CW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts          = '0;
    sts.action   = act_r;
    sts.empty    = empty;
    sts.cnt_done = (idx_r == occ_r) && !pend_r;
    sts.rv_done  = !(idx_r < jdx_r);
    sts.out_free = !out_valid_r || !out_stall;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(DEPTH))
    else $error("occupancy exceeds the queue depth");

  a_full_push_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_push && full |=> $stable(occ_r) && status_r == ST_FULL)
    else $error("push on a full queue changed the occupancy");

  a_pop_drops_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_wb |=> occ_r == $past(occ_r) - CW'(1))
    else $error("pop did not remove exactly one entry");

  a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register loaded while a stalled transfer was pending");

endmodule

`default_nettype wire

// ===== hw/rtl/fifo_with_count_queries.sv =====
// Push and pop go through dispatch (pop also through write-back) to the result register.
// Count requests walk the stored entries one entry per read before loading the result.
// Reverse swaps each pair by two reads then two writes, as the store has one write port.
// One request is in flight at a time; a stalled result delays the next input transfer.
// Reset clears the pointers, occupancy and result valid; the entry store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module fifo_with_count_queries
  import fwcq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  fwcq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  fwcq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
